### rtl/tplq_pkg.sv
// ----------------------------------------------------------------------------
// tplq_pkg
// Shared types, constants and helper functions for the three-level
// strict-priority queue unit.
// ----------------------------------------------------------------------------
package tplq_pkg;

    localparam int LEVEL_DEPTH = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int NUM_LEVELS  = 3;

    localparam int FIELD_W     = 32;
    localparam int LVL_W       = 2;
    localparam int PTR_W       = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
    localparam int STORE_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic [LVL_W-1:0] LVL_LOW    = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MEDIUM = 2'd1;
    localparam logic [LVL_W-1:0] LVL_HIGH   = 2'd2;
    localparam logic [LVL_W-1:0] LVL_NONE   = 2'd3;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

    typedef logic [NUM_LEVELS-1:0][CNT_W-1:0] cnt_vec_t;
    typedef logic [NUM_LEVELS-1:0][PTR_W-1:0] ptr_vec_t;

    typedef struct packed {
        logic [FIELD_W-1:0] popped_value;
        logic               popped_valid;
        logic [FIELD_W-1:0] head_value;
        logic               head_valid;
        logic               is_empty;
        err_t               error_code;
    } rsp_t;

    // Lowest level that holds an element, LVL_NONE when all are empty.
    function automatic logic [LVL_W-1:0] first_busy(cnt_vec_t cnt);
        logic [LVL_W-1:0] sel;
        sel = LVL_NONE;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (cnt[l] != '0) begin
                sel = LVL_W'(l);
            end
        end
        return sel;
    endfunction

    function automatic logic [PTR_W-1:0] advance(logic [PTR_W-1:0] p);
        return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(logic [LVL_W-1:0] l,
                                                      logic [PTR_W-1:0] p);
        return ADDR_W'(l) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(p);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] to_store(logic [FIELD_W-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] from_store(logic [DATA_WIDTH-1:0] s);
        logic [63:0] wide;
        wide = 64'(s);
        return wide[FIELD_W-1:0];
    endfunction

endpackage

### rtl/tplq_ifs.sv
// ----------------------------------------------------------------------------
// tplq request and response channels
// Valid/ready channels of the queue unit; a transaction completes on a
// rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface tplq_req_if;
    import tplq_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [FIELD_W-1:0] data_value;
    logic [LVL_W-1:0]   level;

    modport source (output valid, output kind, output data_value, output level,
                    input ready);
    modport sink   (input valid, input kind, input data_value, input level,
                    output ready);
endinterface

interface tplq_rsp_if;
    import tplq_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] popped_value;
    logic               popped_valid;
    logic [FIELD_W-1:0] head_value;
    logic               head_valid;
    logic               is_empty;
    logic [1:0]         error_code;

    modport source (output valid, output popped_value, output popped_valid,
                    output head_value, output head_valid, output is_empty,
                    output error_code, input ready);
    modport sink   (input valid, input popped_value, input popped_valid,
                    input head_value, input head_valid, input is_empty,
                    input error_code, output ready);
endinterface

### rtl/three_level_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// three_level_priority_queue_unit
// Three FIFO levels in one shared store behind a single request channel.
// ----------------------------------------------------------------------------
// Each request (push or pop) yields one response transaction. Once a request
// has loaded its response, the unit is ready for the next request. A request
// that leaves the queue empty skips the head read. The element store has a
// single read port, so a pop reads the removed element and then the new head.
// Every request that leaves an element in the queue ends with one registered
// read of the new head. A push that finds room first writes the store, and a
// pop that finds an element first reads the removed element. Levels are served
// low first, then medium, then high. A push with level 3 goes to the high
// level. Pointers and fill counts live in flip-flops and clear on reset; the
// store needs no clearing pass. The response sits in an output register, so
// the next request is taken while the previous response waits. A second
// finished response holds the unit until the first one is taken.
// ----------------------------------------------------------------------------
module three_level_priority_queue_unit
    import tplq_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    tplq_req_if.sink       req,
    tplq_rsp_if.source     rsp
);

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_POP_WAIT  = 5'b00010,
        ST_HEAD      = 5'b00100,
        ST_HEAD_WAIT = 5'b01000,
        ST_DONE      = 5'b10000
    } state_t;

    state_t   state_reg, state_next;
    cnt_vec_t cnt_reg, cnt_next;
    ptr_vec_t rp_reg, rp_next;
    ptr_vec_t wp_reg, wp_next;
    rsp_t     res_reg, res_next;
    rsp_t     out_reg, out_next;
    logic     out_valid_reg, out_valid_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    tplq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.popped_value = out_reg.popped_value;
    assign rsp.popped_valid = out_reg.popped_valid;
    assign rsp.head_value   = out_reg.head_value;
    assign rsp.head_valid   = out_reg.head_valid;
    assign rsp.is_empty     = out_reg.is_empty;
    assign rsp.error_code   = out_reg.error_code;

    always_comb
    begin
        rsp_t             cur;
        logic [LVL_W-1:0] lvl;
        logic [LVL_W-1:0] fb;
        logic             issue_head;
        logic             finish;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = to_store(req.data_value);
        ram_re         = 1'b0;
        ram_raddr      = '0;
        cur            = res_reg;
        lvl            = LVL_HIGH;
        fb             = first_busy(cnt_reg);
        issue_head     = 1'b0;
        finish         = 1'b0;

        // drop the response once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                cur              = '0;
                cur.error_code   = ERR_OK;
                if (req.valid)
                begin
                    if (req.kind == KIND_PUSH)
                    begin
                        case (req.level)
                            LVL_LOW:    lvl = LVL_LOW;
                            LVL_MEDIUM: lvl = LVL_MEDIUM;
                            default:    lvl = LVL_HIGH;
                        endcase
                        if (cnt_reg[lvl] == CNT_W'(LEVEL_DEPTH))
                        begin
                            cur.error_code = ERR_FULL;
                        end
                        else
                        begin
                            ram_we        = 1'b1;
                            ram_waddr     = store_addr(lvl, wp_reg[lvl]);
                            wp_next[lvl]  = advance(wp_reg[lvl]);
                            cnt_next[lvl] = cnt_reg[lvl] + CNT_W'(1);
                        end
                        state_next = ST_HEAD;
                    end
                    else if (fb == LVL_NONE)
                    begin
                        cur.error_code = ERR_EMPTY;
                        state_next     = ST_HEAD;
                    end
                    else
                    begin
                        ram_re       = 1'b1;
                        ram_raddr    = store_addr(fb, rp_reg[fb]);
                        rp_next[fb]  = advance(rp_reg[fb]);
                        cnt_next[fb] = cnt_reg[fb] - CNT_W'(1);
                        state_next   = ST_POP_WAIT;
                    end
                    res_next = cur;
                end
            end

            ST_POP_WAIT:
            begin
                cur.popped_value = from_store(ram_rdata);
                cur.popped_valid = 1'b1;
                issue_head       = 1'b1;
            end

            ST_HEAD:
            begin
                issue_head = 1'b1;
            end

            ST_HEAD_WAIT:
            begin
                cur.head_value = from_store(ram_rdata);
                cur.head_valid = 1'b1;
                cur.is_empty   = 1'b0;
                finish         = 1'b1;
            end

            ST_DONE:
            begin
                finish = 1'b1;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // the push write lands in the store before the head read is issued, so
        // the head read always sees the latest push
        if (issue_head)
        begin
            if (fb == LVL_NONE)
            begin
                cur.head_value = '0;
                cur.head_valid = 1'b0;
                cur.is_empty   = 1'b1;
                finish         = 1'b1;
            end
            else
            begin
                ram_re     = 1'b1;
                ram_raddr  = store_addr(fb, rp_reg[fb]);
                res_next   = cur;
                state_next = ST_HEAD_WAIT;
            end
        end

        if (finish)
        begin
            if (!out_valid_reg || rsp.ready)
            begin
                out_next       = cur;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            else
            begin
                res_next   = cur;
                state_next = ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rp_reg        <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
    end

endmodule

### rtl/tplq_ram.sv
// ----------------------------------------------------------------------------
// tplq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tplq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### test/three_level_priority_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// three_level_priority_queue_unit_tb
// Drives push and pop requests into the three-level priority queue, tracks a
// shadow copy of the three FIFOs and checks every response field in order.
// The sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module three_level_priority_queue_unit_tb;
    import tplq_pkg::*;

    localparam int RANDOM_OPS   = 1850;
    localparam int RESET_CYCLES = 4;
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE_WAIT  = 20;
    localparam int IDLE_LIMIT   = 4000;

    typedef struct {
        logic               kind;
        logic [FIELD_W-1:0] data;
        logic [LVL_W-1:0]   level;
        bit                 drain;
    } queue_op_t;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_COMB
    } rx_mode_e;

    logic clk = 1'b0;
    logic rst_n;

    tplq_req_if req_bus ();
    tplq_rsp_if rsp_bus ();

    three_level_priority_queue_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #1 clk = ~clk;

    queue_op_t pending_ops[$];
    rsp_t      queue_replies[$];

    logic [DATA_WIDTH-1:0] shadow_mem [NUM_LEVELS][LEVEL_DEPTH];
    int shadow_rd   [NUM_LEVELS];
    int shadow_wr   [NUM_LEVELS];
    int shadow_fill [NUM_LEVELS];

    int fault_count  = 0;
    int replies_seen = 0;
    int idle_cycles  = 0;
    bit req_taken    = 1'b0;

    // First level holding an element in serving order, NUM_LEVELS if none.
    function automatic int serving_level();
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (shadow_fill[l] != 0) begin
                return l;
            end
        end
        return NUM_LEVELS;
    endfunction

    // Apply one request to the shadow FIFOs and return the response it yields.
    function automatic rsp_t serve_request(queue_op_t op);
        rsp_t r;
        int   lv;
        r = '0;
        r.error_code = ERR_OK;
        if (op.kind == KIND_PUSH) begin
            lv = (op.level == LVL_LOW) ? 0 : (op.level == LVL_MEDIUM) ? 1 : 2;
            if (shadow_fill[lv] >= LEVEL_DEPTH) begin
                r.error_code = ERR_FULL;
            end
            else begin
                shadow_mem[lv][shadow_wr[lv]] = DATA_WIDTH'(op.data);
                shadow_wr[lv] = (shadow_wr[lv] + 1) % LEVEL_DEPTH;
                shadow_fill[lv]++;
            end
        end
        else begin
            lv = serving_level();
            if (lv == NUM_LEVELS) begin
                r.error_code = ERR_EMPTY;
            end
            else begin
                r.popped_value = FIELD_W'(shadow_mem[lv][shadow_rd[lv]]);
                r.popped_valid = 1'b1;
                shadow_rd[lv] = (shadow_rd[lv] + 1) % LEVEL_DEPTH;
                shadow_fill[lv]--;
            end
        end
        lv = serving_level();
        if (lv != NUM_LEVELS) begin
            r.head_value = FIELD_W'(shadow_mem[lv][shadow_rd[lv]]);
            r.head_valid = 1'b1;
        end
        r.is_empty = ~r.head_valid;
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] random_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    task automatic add_op(logic kind, logic [FIELD_W-1:0] data, logic [LVL_W-1:0] level);
        queue_op_t op;
        op.kind  = kind;
        op.data  = data;
        op.level = level;
        op.drain = 1'b0;
        pending_ops.push_back(op);
    endtask

    task automatic report_field(string name, logic [FIELD_W-1:0] want,
                                logic [FIELD_W-1:0] got);
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        fault_count++;
    endtask

    // Stimulus, reset and end of run
    initial begin
        int added;
        int seg;
        int len;
        logic [LVL_W-1:0] lvl;

        rst_n              = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.kind       = KIND_PUSH;
        req_bus.data_value = '0;
        req_bus.level      = LVL_LOW;
        rsp_bus.ready      = 1'b0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            shadow_rd[l]   = 0;
            shadow_wr[l]   = 0;
            shadow_fill[l] = 0;
        end

        // pop on empty, level 3 folding into high, medium served before high
        add_op(KIND_POP, 32'hFFFF_FFFF, LVL_NONE);
        add_op(KIND_PUSH, 32'h0000_0000, LVL_HIGH);
        add_op(KIND_PUSH, 32'hFFFF_FFFF, LVL_MEDIUM);
        add_op(KIND_PUSH, 32'h5A5A_A5A5, LVL_NONE);
        add_op(KIND_POP, 32'h1234_5678, LVL_HIGH);
        // fill low to the brim, then overflow it
        for (int i = 0; i < LEVEL_DEPTH + 1; i++) begin
            add_op(KIND_PUSH, (i % 2 == 0) ? 32'hFFFF_FFFF - i : i, LVL_LOW);
        end

        added = 0;
        while (added < RANDOM_OPS) begin
            seg = $urandom_range(0, 9);
            if (seg < 3) begin
                lvl = LVL_W'($urandom_range(0, 3));
                len = $urandom_range(8, 20);
                for (int i = 0; i < len; i++) begin
                    add_op(KIND_PUSH, random_word(), lvl);
                end
            end
            else if (seg < 5) begin
                len = $urandom_range(5, 30);
                for (int i = 0; i < len; i++) begin
                    add_op(KIND_POP, random_word(), LVL_W'($urandom_range(0, 3)));
                end
            end
            else begin
                len = $urandom_range(10, 40);
                for (int i = 0; i < len; i++) begin
                    add_op($urandom_range(0, 1) ? KIND_POP : KIND_PUSH, random_word(),
                           LVL_W'($urandom_range(0, 3)));
                end
            end
            added += len;
        end
        // sender pauses here until every outstanding response is back
        pending_ops[pending_ops.size() / 2].drain = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0) @(posedge clk);
        while (queue_replies.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        if (fault_count == 0) begin
            $display("Test completed successfully");
        end
        else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Request driver: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge clk) begin
        if (rst_n && !(req_bus.valid && !req_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                req_bus.valid <= 1'b0;
            end
            else if (pending_ops.size() == 0 ||
                     (pending_ops[0].drain && queue_replies.size() != 0)) begin
                req_bus.valid <= 1'b0;
            end
            else begin
                req_bus.valid      <= 1'b1;
                req_bus.kind       <= pending_ops[0].kind;
                req_bus.data_value <= pending_ops[0].data;
                req_bus.level      <= pending_ops[0].level;
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // Response receiver: own stall pattern plus long hold-offs
    rx_mode_e rx_mode    = RX_OPEN;
    int       epoch_left = 0;
    int       comb_phase = 0;
    int       hold_left  = 0;
    int       next_hold  = 300;

    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (replies_seen >= next_hold) begin
                hold_left = HOLD_CYCLES - 1;
                next_hold += 900;
                rsp_bus.ready <= 1'b0;
            end
            else begin
                if (epoch_left == 0) begin
                    rx_mode    = rx_mode_e'($urandom_range(0, 2));
                    epoch_left = $urandom_range(20, 120);
                end
                epoch_left--;
                comb_phase = (comb_phase + 1) % 3;
                case (rx_mode)
                    RX_OPEN:   rsp_bus.ready <= 1'b1;
                    RX_RANDOM: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                    default:   rsp_bus.ready <= (comb_phase == 0);
                endcase
            end
        end
    end

    // Monitor: check responses, then predict for the accepted request
    always @(posedge clk) begin
        rsp_t want;
        if (rst_n) begin
            req_taken = req_bus.valid && req_bus.ready;
            if (rsp_bus.valid && rsp_bus.ready) begin
                replies_seen++;
                if (queue_replies.size() == 0) begin
                    $display("%0t: response with no request outstanding", $time);
                    fault_count++;
                end
                else begin
                    want = queue_replies.pop_front();
                    if (rsp_bus.popped_value !== want.popped_value)
                        report_field("popped_value", want.popped_value, rsp_bus.popped_value);
                    if (rsp_bus.popped_valid !== want.popped_valid)
                        report_field("popped_valid", want.popped_valid, rsp_bus.popped_valid);
                    if (rsp_bus.head_value !== want.head_value)
                        report_field("head_value", want.head_value, rsp_bus.head_value);
                    if (rsp_bus.head_valid !== want.head_valid)
                        report_field("head_valid", want.head_valid, rsp_bus.head_valid);
                    if (rsp_bus.is_empty !== want.is_empty)
                        report_field("is_empty", want.is_empty, rsp_bus.is_empty);
                    if (rsp_bus.error_code !== 2'(want.error_code))
                        report_field("error_code", 2'(want.error_code), rsp_bus.error_code);
                end
            end
            if (req_taken) begin
                queue_replies.push_back(serve_request(pending_ops.pop_front()));
            end
        end
    end

    // Watchdog: count cycles with no transaction on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
                idle_cycles = 0;
            end
            else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
